@@ hdl/ndd_pkg.sv @@
`timescale 1ns / 1ps

package ndd_pkg;

	localparam int MAX_NODES_DEF = 16;

	localparam int DATA_W  = 32;
	localparam int COEFF_W = 64;
	localparam int DIFF_W  = DATA_W + 1;
	localparam int CFG_W   = 5;
	localparam int IDX_W   = 4;
	localparam int Y_SHIFT = 24;
	localparam int Q_SHIFT = 16;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd11;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [1:0] WSEL_LOAD = 2'd0;
	localparam logic [1:0] WSEL_ZERO = 2'd1;
	localparam logic [1:0] WSEL_QUOT = 2'd2;

	typedef struct packed {
		logic       load;
		logic       cap_query;
		logic       latch_a;
		logic       latch_diff;
		logic       div_start;
		logic       c_we;
		logic [1:0] c_wsel;
		logic       ev_init;
		logic       mul_prep;
		logic       mul_lo;
		logic       mul_hi;
		logic       mul_fin;
		logic       acc_add;
		logic       out_load;
		logic       out_dup;
	} ndd_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic dx_zero;
		logic out_free;
	} ndd_stat_t;

endpackage

@@ hdl/ndd_ram.sv @@
`timescale 1ns / 1ps

module ndd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/ndd_div.sv @@
`timescale 1ns / 1ps

module ndd_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic signed [ndd_pkg::COEFF_W-1:0]     num,
	input  logic signed [ndd_pkg::DIFF_W-1:0]      den,
	output logic                                   busy,
	output logic signed [ndd_pkg::COEFF_W-1:0]     quot
);

	localparam int NW   = ndd_pkg::COEFF_W;
	localparam int DW   = ndd_pkg::DIFF_W;
	localparam int QW   = NW + ndd_pkg::Q_SHIFT;
	localparam int RW   = DW + 1;
	localparam int CNTW = $clog2(QW + 1);

	logic [QW-1:0]   dvd_q;
	logic [RW-1:0]   rem_q;
	logic [DW-1:0]   dmag_q;
	logic            neg_q;
	logic            busy_q;
	logic [CNTW-1:0] cnt_q;

	logic [NW-1:0] num_mag;
	logic [DW-1:0] den_mag;
	logic [RW-1:0] rem_sh;
	logic          ge;
	logic          clip;

	assign num_mag = num[NW-1] ? (NW'(0) - num) : num;
	assign den_mag = den[DW-1] ? (DW'(0) - den) : den;
	assign rem_sh  = {rem_q[RW-2:0], dvd_q[QW-1]};
	assign ge      = rem_sh >= {1'b0, dmag_q};

	// Restoring division, one quotient bit per cycle; the dividend register
	// fills up with the quotient.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNTW'(1);
			if (cnt_q == CNTW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= {num_mag, ndd_pkg::Q_SHIFT'(0)};
			rem_q  <= '0;
			dmag_q <= den_mag;
			neg_q  <= num[NW-1] ^ den[DW-1];
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, dmag_q}) : rem_sh;
			dvd_q <= {dvd_q[QW-2:0], ge};
		end
	end

	// A quotient of 2^63 or more clips to the signed 64-bit range.
	assign clip = |dvd_q[QW-1:NW-1];
	assign busy = busy_q;

	always_comb begin
		if (clip) begin
			quot = neg_q ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}};
		end else if (neg_q) begin
			quot = NW'(0) - dvd_q[NW-1:0];
		end else begin
			quot = dvd_q[NW-1:0];
		end
	end

endmodule

@@ hdl/ndd_datapath.sv @@
`timescale 1ns / 1ps

module ndd_datapath #(
	parameter int MAX_NODES = ndd_pkg::MAX_NODES_DEF,
	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ndd_pkg::ndd_cmd_t                    cmd,
	output ndd_pkg::ndd_stat_t                   stat,
	input  logic [AW-1:0]                        waddr,
	input  logic [AW-1:0]                        x_raddr,
	input  logic [AW-1:0]                        c_raddr,
	input  logic signed [ndd_pkg::DATA_W-1:0]    node_abscissa,
	input  logic signed [ndd_pkg::DATA_W-1:0]    node_ordinate,
	input  logic signed [ndd_pkg::DATA_W-1:0]    query_point,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [ndd_pkg::DATA_W-1:0]    interp_value,
	output logic [1:0]                           status
);

	localparam int XW = ndd_pkg::DATA_W;
	localparam int CW = ndd_pkg::COEFF_W;
	localparam int DW = ndd_pkg::DIFF_W;
	localparam int HW = CW / 2;
	localparam int RSW = CW - ndd_pkg::Y_SHIFT;

	localparam logic [CW-1:0] POS_LIM = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] NEG_LIM = {1'b1, {(CW-1){1'b0}}};

	logic [XW-1:0] x_rdata;
	logic [CW-1:0] c_rdata;
	logic [CW-1:0] c_wdata;
	logic [CW-1:0] load_coeff;
	logic [CW-1:0] div_quot;
	logic          div_busy;

	logic signed [XW-1:0] query_q;
	logic signed [XW-1:0] xa_q;
	logic signed [CW-1:0] ca_q;
	logic signed [DW-1:0] dx_q;
	logic signed [CW-1:0] dy_q;
	logic signed [CW-1:0] acc_q;
	logic signed [CW-1:0] ct_q;
	logic [CW-1:0]        am_q;
	logic [DW-1:0]        bm_q;
	logic                 neg_q;
	logic [CW-1:0]        plo_q;
	logic [CW-1:0]        phi_q;
	logic signed [CW-1:0] p_q;
	logic                 sat_q;

	logic                 out_valid_q;
	logic signed [XW-1:0] out_value_q;
	logic [1:0]           out_status_q;

	assign load_coeff = {{(CW-XW-ndd_pkg::Y_SHIFT){node_ordinate[XW-1]}}, node_ordinate,
		ndd_pkg::Y_SHIFT'(0)};

	always_comb begin
		case (cmd.c_wsel)
			ndd_pkg::WSEL_LOAD: c_wdata = load_coeff;
			ndd_pkg::WSEL_QUOT: c_wdata = div_quot;
			default:            c_wdata = '0;
		endcase
	end

	ndd_ram #(.WIDTH(XW), .DEPTH(MAX_NODES)) u_xram (
		.clk  (clk),
		.we   (cmd.load),
		.waddr(waddr),
		.wdata(node_abscissa),
		.raddr(x_raddr),
		.rdata(x_rdata)
	);

	ndd_ram #(.WIDTH(CW), .DEPTH(MAX_NODES)) u_cram (
		.clk  (clk),
		.we   (cmd.load || cmd.c_we),
		.waddr(waddr),
		.wdata(c_wdata),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	ndd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (dy_q),
		.den   (dx_q),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	// Rebuild differences: dx is exact in 33 bits, dy saturates.
	logic signed [DW-1:0] dx_d;
	logic signed [CW:0]   dy_wide;
	logic signed [CW-1:0] dy_d;

	assign dx_d    = {xa_q[XW-1], xa_q} - {x_rdata[XW-1], x_rdata};
	assign dy_wide = {ca_q[CW-1], ca_q} - {c_rdata[CW-1], c_rdata};
	always_comb begin
		if (dy_wide[CW] != dy_wide[CW-1]) begin
			dy_d = dy_wide[CW] ? NEG_LIM : POS_LIM;
		end else begin
			dy_d = dy_wide[CW-1:0];
		end
	end

	// Horner step operands.
	logic signed [DW-1:0] hd;
	logic [CW-1:0]        acc_mag;
	logic [DW-1:0]        hd_mag;

	assign hd      = {query_q[XW-1], query_q} - {x_rdata[XW-1], x_rdata};
	assign acc_mag = acc_q[CW-1] ? (CW'(0) - acc_q) : acc_q;
	assign hd_mag  = hd[DW-1] ? (DW'(0) - hd) : hd;

	// One 32x32 multiplier, used for the low and the high half of the
	// accumulator magnitude in turn.
	logic [HW-1:0] mul_a;
	logic [CW-1:0] prod;

	assign mul_a = cmd.mul_hi ? am_q[CW-1:HW] : am_q[HW-1:0];
	assign prod  = mul_a * bm_q[HW-1:0];

	// A multiplier magnitude of exactly 2^32 has zero low bits, so the
	// partial products become plain shifts.
	logic [CW-1:0] hi_part;
	logic [CW-1:0] lo_part;
	logic          hi_clip;
	logic [CW-1:0] m_sum;
	logic signed [CW-1:0] p_d;
	logic          p_sat;

	always_comb begin
		if (bm_q[DW-1]) begin
			hi_part = {am_q[CW-1:HW], HW'(0)};
			lo_part = {am_q[HW-1:0], HW'(0)};
		end else begin
			hi_part = phi_q;
			lo_part = plo_q;
		end
		hi_clip = |hi_part[CW-1:CW-ndd_pkg::Q_SHIFT-1];
		m_sum   = {hi_part[CW-ndd_pkg::Q_SHIFT-1:0], ndd_pkg::Q_SHIFT'(0)}
			+ {ndd_pkg::Q_SHIFT'(0), lo_part[CW-1:ndd_pkg::Q_SHIFT]};
		if (hi_clip) begin
			p_sat = 1'b1;
			p_d   = neg_q ? NEG_LIM : POS_LIM;
		end else if (neg_q) begin
			p_sat = m_sum > NEG_LIM;
			p_d   = (m_sum >= NEG_LIM) ? NEG_LIM : (CW'(0) - m_sum);
		end else begin
			p_sat = m_sum > POS_LIM;
			p_d   = (m_sum > POS_LIM) ? POS_LIM : m_sum;
		end
	end

	logic signed [CW:0]   sum_wide;
	logic signed [CW-1:0] sum_d;
	logic                 sum_sat;

	assign sum_wide = {ct_q[CW-1], ct_q} + {p_q[CW-1], p_q};
	assign sum_sat  = sum_wide[CW] != sum_wide[CW-1];
	assign sum_d    = sum_sat ? (sum_wide[CW] ? NEG_LIM : POS_LIM) : sum_wide[CW-1:0];

	// Final scaling: arithmetic shift is floor, then clip to Q16.16.
	logic [RSW-1:0]       res_wide;
	logic                 res_clip;
	logic signed [XW-1:0] res_value;
	logic [1:0]           res_status;

	assign res_wide = acc_q[CW-1:ndd_pkg::Y_SHIFT];
	assign res_clip = !((&res_wide[RSW-1:XW-1]) || !(|res_wide[RSW-1:XW-1]));

	always_comb begin
		if (cmd.out_dup) begin
			res_value  = '0;
			res_status = ndd_pkg::ST_DUP;
		end else begin
			if (res_clip) begin
				res_value = res_wide[RSW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
			end else begin
				res_value = res_wide[XW-1:0];
			end
			res_status = (sat_q || res_clip) ? ndd_pkg::ST_SAT : ndd_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_query) begin
			query_q <= query_point;
		end
		if (cmd.latch_a) begin
			xa_q <= x_rdata;
			ca_q <= c_rdata;
		end
		if (cmd.latch_diff) begin
			dx_q <= dx_d;
			dy_q <= dy_d;
		end
		if (cmd.ev_init) begin
			acc_q <= c_rdata;
		end else if (cmd.acc_add) begin
			acc_q <= sum_d;
		end
		if (cmd.mul_prep) begin
			am_q  <= acc_mag;
			bm_q  <= hd_mag;
			neg_q <= acc_q[CW-1] ^ hd[DW-1];
			ct_q  <= c_rdata;
		end
		if (cmd.mul_lo) begin
			plo_q <= prod;
		end
		if (cmd.mul_hi) begin
			phi_q <= prod;
		end
		if (cmd.mul_fin) begin
			p_q <= p_d;
		end
		if (cmd.out_load) begin
			out_value_q  <= res_value;
			out_status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ev_init) begin
				sat_q <= 1'b0;
			end else if (cmd.mul_fin) begin
				sat_q <= sat_q | p_sat;
			end else if (cmd.acc_add) begin
				sat_q <= sat_q | sum_sat;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.div_busy = div_busy;
	assign stat.dx_zero  = (dx_q == '0);
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign interp_value = out_value_q;
	assign status       = out_status_q;

endmodule

@@ hdl/ndd_ctrl.sv @@
`timescale 1ns / 1ps

module ndd_ctrl #(
	parameter int MAX_NODES = ndd_pkg::MAX_NODES_DEF,
	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [ndd_pkg::IDX_W-1:0]     node_index,
	input  logic                          cfg_we,
	input  logic [ndd_pkg::CFG_W-1:0]     cfg_wdata,
	input  ndd_pkg::ndd_stat_t            stat,
	output ndd_pkg::ndd_cmd_t             cmd,
	output logic [AW-1:0]                 waddr,
	output logic [AW-1:0]                 x_raddr,
	output logic [AW-1:0]                 c_raddr
);

	localparam int NW = $clog2(MAX_NODES + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_RB_A     = 4'd1;
	localparam logic [3:0] S_RB_B     = 4'd2;
	localparam logic [3:0] S_RB_C     = 4'd3;
	localparam logic [3:0] S_RB_D     = 4'd4;
	localparam logic [3:0] S_RB_DIV   = 4'd5;
	localparam logic [3:0] S_RB_NEXT  = 4'd6;
	localparam logic [3:0] S_EV_START = 4'd7;
	localparam logic [3:0] S_EV_INIT  = 4'd8;
	localparam logic [3:0] S_EV_RD    = 4'd9;
	localparam logic [3:0] S_EV_M0    = 4'd10;
	localparam logic [3:0] S_EV_M1    = 4'd11;
	localparam logic [3:0] S_EV_M2    = 4'd12;
	localparam logic [3:0] S_EV_M3    = 4'd13;
	localparam logic [3:0] S_EV_ADD   = 4'd14;
	localparam logic [3:0] S_FINISH   = 4'd15;

	logic [3:0]               state_q, state_d;
	logic [ndd_pkg::CFG_W-1:0] node_count_q;
	logic                     cvalid_q;
	logic                     dup_q;
	logic [AW-1:0]            i_q, j_q, k_q;
	logic [NW-1:0]            n_sel;
	logic [AW-1:0]            n_m1, n_m2;
	logic                     accept;
	logic                     load_ok;

	always_comb begin
		if (node_count_q < ndd_pkg::CFG_W'(2)) begin
			n_sel = NW'(2);
		end else if (32'(node_count_q) > 32'(MAX_NODES)) begin
			n_sel = NW'(MAX_NODES);
		end else begin
			n_sel = NW'(node_count_q);
		end
	end

	assign n_m1    = AW'(n_sel - NW'(1));
	assign n_m2    = AW'(n_sel - NW'(2));
	assign accept  = in_valid && (state_q == S_IDLE);
	assign load_ok = 32'(node_index) < 32'(MAX_NODES);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		waddr   = i_q;
		x_raddr = i_q;
		c_raddr = i_q;
		case (state_q)
			S_IDLE: begin
				waddr = AW'(node_index);
				cmd.c_wsel = ndd_pkg::WSEL_LOAD;
				if (accept) begin
					if (opcode == ndd_pkg::OP_LOAD) begin
						cmd.load = load_ok;
					end else begin
						cmd.cap_query = 1'b1;
						state_d = cvalid_q ? S_EV_START : S_RB_A;
					end
				end
			end
			S_RB_A: begin
				state_d = S_RB_B;
			end
			S_RB_B: begin
				x_raddr = i_q - j_q;
				c_raddr = i_q - AW'(1);
				cmd.latch_a = 1'b1;
				state_d = S_RB_C;
			end
			S_RB_C: begin
				cmd.latch_diff = 1'b1;
				state_d = S_RB_D;
			end
			S_RB_D: begin
				if (stat.dx_zero) begin
					cmd.c_we   = 1'b1;
					cmd.c_wsel = ndd_pkg::WSEL_ZERO;
					state_d = S_RB_NEXT;
				end else begin
					cmd.div_start = 1'b1;
					state_d = S_RB_DIV;
				end
			end
			S_RB_DIV: begin
				if (!stat.div_busy) begin
					cmd.c_we   = 1'b1;
					cmd.c_wsel = ndd_pkg::WSEL_QUOT;
					state_d = S_RB_NEXT;
				end
			end
			S_RB_NEXT: begin
				if (i_q == j_q && j_q == n_m1) begin
					state_d = S_EV_START;
				end else begin
					state_d = S_RB_A;
				end
			end
			S_EV_START: begin
				c_raddr = n_m1;
				state_d = dup_q ? S_FINISH : S_EV_INIT;
			end
			S_EV_INIT: begin
				cmd.ev_init = 1'b1;
				state_d = S_EV_RD;
			end
			S_EV_RD: begin
				x_raddr = k_q;
				c_raddr = k_q;
				state_d = S_EV_M0;
			end
			S_EV_M0: begin
				cmd.mul_prep = 1'b1;
				state_d = S_EV_M1;
			end
			S_EV_M1: begin
				cmd.mul_lo = 1'b1;
				state_d = S_EV_M2;
			end
			S_EV_M2: begin
				cmd.mul_hi = 1'b1;
				state_d = S_EV_M3;
			end
			S_EV_M3: begin
				cmd.mul_fin = 1'b1;
				state_d = S_EV_ADD;
			end
			S_EV_ADD: begin
				cmd.acc_add = 1'b1;
				state_d = (k_q == '0) ? S_FINISH : S_EV_RD;
			end
			S_FINISH: begin
				cmd.out_dup = dup_q;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= ndd_pkg::NODE_COUNT_RST;
			cvalid_q     <= 1'b0;
			dup_q        <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (opcode == ndd_pkg::OP_LOAD) begin
							if (load_ok) begin
								cvalid_q <= 1'b0;
							end
						end else if (!cvalid_q) begin
							dup_q <= 1'b0;
							j_q   <= AW'(1);
							i_q   <= n_m1;
						end
					end
				end
				S_RB_D: begin
					if (stat.dx_zero) begin
						dup_q <= 1'b1;
					end
				end
				S_RB_NEXT: begin
					// Each column of the table runs from the top row down to row j.
					if (i_q == j_q) begin
						if (j_q == n_m1) begin
							cvalid_q <= 1'b1;
						end else begin
							j_q <= j_q + AW'(1);
							i_q <= n_m1;
						end
					end else begin
						i_q <= i_q - AW'(1);
					end
				end
				S_EV_INIT: begin
					k_q <= n_m2;
				end
				S_EV_ADD: begin
					if (k_q != '0) begin
						k_q <= k_q - AW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hdl/newton_divided_difference_interp_unit.sv @@
`timescale 1ns / 1ps
// A load request is accepted while idle; loads can be accepted back to back.
// An evaluate request runs, per Horner term (n-1 terms for n nodes), one step sequence
// on the shared 32x32 multiplier, then hands over the result once the output is free.
// The first evaluate after a load first rebuilds the coefficients: n*(n-1)/2 table
// entries, each through the 80-step serial divider unless the abscissas are equal.
// Reset clears control state and sets node_count to 11; node memories are not cleared.

module newton_divided_difference_interp_unit #(
	parameter int MAX_NODES = ndd_pkg::MAX_NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              opcode,
	input  logic [ndd_pkg::IDX_W-1:0]         node_index,
	input  logic signed [ndd_pkg::DATA_W-1:0] node_abscissa,
	input  logic signed [ndd_pkg::DATA_W-1:0] node_ordinate,
	input  logic signed [ndd_pkg::DATA_W-1:0] query_point,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ndd_pkg::DATA_W-1:0] interp_value,
	output logic [1:0]                        status,
	input  logic                              cfg_we,
	input  logic [ndd_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

	ndd_pkg::ndd_cmd_t  cmd;
	ndd_pkg::ndd_stat_t stat;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      x_raddr;
	logic [AW-1:0]      c_raddr;

	ndd_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.node_index(node_index),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.stat      (stat),
		.cmd       (cmd),
		.waddr     (waddr),
		.x_raddr   (x_raddr),
		.c_raddr   (c_raddr)
	);

	ndd_datapath #(.MAX_NODES(MAX_NODES)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.waddr        (waddr),
		.x_raddr      (x_raddr),
		.c_raddr      (c_raddr),
		.node_abscissa(node_abscissa),
		.node_ordinate(node_ordinate),
		.query_point  (query_point),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.interp_value (interp_value),
		.status       (status)
	);

endmodule

@@ sim/ndd_checker.sv @@
`timescale 1ns / 1ps

module ndd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              opcode,
	input  logic [ndd_pkg::IDX_W-1:0]         node_index,
	input  logic signed [ndd_pkg::DATA_W-1:0] node_abscissa,
	input  logic signed [ndd_pkg::DATA_W-1:0] node_ordinate,
	input  logic signed [ndd_pkg::DATA_W-1:0] query_point,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [ndd_pkg::DATA_W-1:0] interp_value,
	input  logic [1:0]                        status,
	input  logic                              cfg_we,
	input  logic [ndd_pkg::CFG_W-1:0]         cfg_wdata,
	output int                                fail_count,
	output int                                pending
);

	localparam int NODES = ndd_pkg::MAX_NODES_DEF;
	localparam longint unsigned TOP_BIT = 64'h8000_0000_0000_0000;

	typedef struct {
		logic signed [ndd_pkg::DATA_W-1:0] value;
		logic [1:0]                        code;
	} interp_result_t;

	interp_result_t results_due[$];

	longint x_nodes[NODES];
	longint coeffs[NODES];
	bit coeffs_built;
	bit dup_seen;
	logic [ndd_pkg::CFG_W-1:0] count_reg;

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint apply_sign(longint unsigned m, bit neg, inout bit clip);
		if (neg) begin
			if (m >= TOP_BIT) begin
				if (m > TOP_BIT)
					clip = 1;
				return longint'(TOP_BIT);
			end
			return -longint'(m);
		end
		if (m >= TOP_BIT) begin
			clip = 1;
			return longint'(TOP_BIT - 1);
		end
		return longint'(m);
	endfunction

	function automatic longint clip_add(longint a, longint b, inout bit clip);
		longint s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63]) begin
			clip = 1;
			return a[63] ? longint'(TOP_BIT) : longint'(TOP_BIT - 1);
		end
		return s;
	endfunction

	function automatic longint clip_sub(longint a, longint b, inout bit clip);
		longint s;
		s = a - b;
		if (a[63] != b[63] && s[63] != a[63]) begin
			clip = 1;
			return a[63] ? longint'(TOP_BIT) : longint'(TOP_BIT - 1);
		end
		return s;
	endfunction

	function automatic longint q16_divide(longint num, longint den, inout bit clip);
		longint unsigned n, d, q, r, m;
		n = magnitude(num);
		d = magnitude(den);
		q = n / d;
		r = n % d;
		if (q >= (64'd1 << 47))
			m = TOP_BIT | 64'd1;
		else
			m = (q << 16) + ((r << 16) / d);
		return apply_sign(m, (num < 0) != (den < 0), clip);
	endfunction

	function automatic longint q16_multiply(longint a, longint b, inout bit clip);
		longint unsigned am, bm, hi, lo, m;
		am = magnitude(a);
		bm = magnitude(b);
		hi = (am >> 32) * bm;
		lo = (am & 64'hFFFF_FFFF) * bm;
		if (hi >= (64'd1 << 47))
			m = TOP_BIT | 64'd1;
		else
			m = (hi << 16) + (lo >> 16);
		return apply_sign(m, (a < 0) != (b < 0), clip);
	endfunction

	function automatic int nodes_in_use();
		if (count_reg < 2)
			return 2;
		if (count_reg > NODES)
			return NODES;
		return int'(count_reg);
	endfunction

	// In-place divided-difference table; saturation here raises no status.
	task automatic rebuild_table(int n);
		bit dropped;
		longint dx;
		dropped = 0;
		dup_seen = 0;
		for (int j = 1; j < n; j++) begin
			for (int i = n - 1; i >= j; i--) begin
				dx = x_nodes[i] - x_nodes[i-j];
				if (dx == 0) begin
					dup_seen = 1;
					coeffs[i] = 0;
				end else begin
					coeffs[i] = q16_divide(clip_sub(coeffs[i], coeffs[i-1], dropped), dx, dropped);
				end
			end
		end
		coeffs_built = 1;
	endtask

	task automatic predict_evaluate(logic signed [ndd_pkg::DATA_W-1:0] q_in);
		interp_result_t r;
		int n;
		bit clip;
		longint q, acc, res;
		n = nodes_in_use();
		clip = 0;
		if (!coeffs_built)
			rebuild_table(n);
		if (dup_seen) begin
			r.value = '0;
			r.code = ndd_pkg::ST_DUP;
		end else begin
			q = longint'(q_in);
			acc = coeffs[n-1];
			for (int k = n - 2; k >= 0; k--)
				acc = clip_add(coeffs[k], q16_multiply(acc, q - x_nodes[k], clip), clip);
			res = acc >>> ndd_pkg::Y_SHIFT;
			if (res > 64'sd2147483647) begin
				res = 64'sd2147483647;
				clip = 1;
			end
			if (res < -64'sd2147483648) begin
				res = -64'sd2147483648;
				clip = 1;
			end
			r.value = res[ndd_pkg::DATA_W-1:0];
			r.code = clip ? ndd_pkg::ST_SAT : ndd_pkg::ST_OK;
		end
		results_due.push_back(r);
	endtask

	task automatic report_mismatch(string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		interp_result_t want;
		if (!arst_n) begin
			coeffs_built = 0;
			dup_seen = 0;
			count_reg = ndd_pkg::NODE_COUNT_RST;
			results_due.delete();
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result value=%0d status=%0d",
						interp_value, status));
				end else begin
					want = results_due.pop_front();
					if (interp_value !== want.value)
						report_mismatch($sformatf("interp_value %0d, expected %0d",
							interp_value, want.value));
					if (status !== want.code)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.code));
				end
			end
			if (in_valid && !in_stall) begin
				if (opcode == ndd_pkg::OP_LOAD) begin
					x_nodes[node_index] = longint'(node_abscissa);
					coeffs[node_index] = longint'(node_ordinate) <<< ndd_pkg::Y_SHIFT;
					coeffs_built = 0;
				end else begin
					predict_evaluate(query_point);
				end
			end
			if (cfg_we)
				count_reg = cfg_wdata;
			pending = results_due.size();
		end
	end
endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	logic                               clk = 0;
	logic                               arst_n = 0;
	logic                               in_valid = 0;
	logic                               in_stall;
	logic                               opcode = ndd_pkg::OP_LOAD;
	logic [ndd_pkg::IDX_W-1:0]          node_index = '0;
	logic signed [ndd_pkg::DATA_W-1:0]  node_abscissa = '0;
	logic signed [ndd_pkg::DATA_W-1:0]  node_ordinate = '0;
	logic signed [ndd_pkg::DATA_W-1:0]  query_point = '0;
	logic                               out_valid;
	logic                               out_stall = 0;
	logic signed [ndd_pkg::DATA_W-1:0]  interp_value;
	logic [1:0]                         status;
	logic                               cfg_we = 0;
	logic [ndd_pkg::CFG_W-1:0]          cfg_wdata = '0;
	int                                 fail_count;
	int                                 pending;

	bit quiet = 0;
	int sent = 0;
	int active_nodes = 11;
	int base_x, step_x;

	always #5 clk = ~clk;

	newton_divided_difference_interp_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .node_index(node_index), .node_abscissa(node_abscissa),
		.node_ordinate(node_ordinate), .query_point(query_point),
		.out_valid(out_valid), .out_stall(out_stall),
		.interp_value(interp_value), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	ndd_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .node_index(node_index), .node_abscissa(node_abscissa),
		.node_ordinate(node_ordinate), .query_point(query_point),
		.out_valid(out_valid), .out_stall(out_stall),
		.interp_value(interp_value), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 9);
	end

	task automatic send(logic op, int idx, int x, int y, int q);
		@(negedge clk);
		if (!quiet && $urandom_range(99) < 9) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		node_index <= idx[ndd_pkg::IDX_W-1:0];
		node_abscissa <= x;
		node_ordinate <= y;
		query_point <= q;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic evaluate_at(int q);
		send(ndd_pkg::OP_EVAL, $urandom, $urandom, $urandom, q);
	endtask

	// Drain all results, give trailing loads time to land, then write the count.
	task automatic set_node_count(logic [ndd_pkg::CFG_W-1:0] v);
		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		active_nodes = v < 2 ? 2 : (v > 16 ? 16 : int'(v));
	endtask

	// Mostly well-spaced nodes; sometimes a repeated abscissa or raw random values.
	task automatic load_nodes(int first, int last);
		int mode, x;
		mode = $urandom_range(9);
		base_x = (int'($urandom_range(400)) - 200) <<< 16;
		step_x = $urandom_range(16384, 262144);
		for (int i = first; i <= last; i++) begin
			x = base_x + i * step_x + int'($urandom_range(255));
			if (mode == 7 && i == last && i > 0)
				x = base_x + (i - 1) * step_x;
			if (mode == 8)
				x = $urandom;
			if (mode == 7 && i == last && i > 0 && first == last)
				x = $urandom;
			send(ndd_pkg::OP_LOAD, i, x, (mode == 8) ? int'($urandom)
				: int'($urandom_range(32'h0100_0000)) - 32'sh0080_0000, $urandom);
		end
		if (mode == 7 && last > first) begin
			// Repeat the previous abscissa exactly.
			send(ndd_pkg::OP_LOAD, last, base_x + (last - 1) * step_x + 0, $urandom, $urandom);
			send(ndd_pkg::OP_LOAD, last - 1, base_x + (last - 1) * step_x, $urandom, $urandom);
		end
	endtask

	task automatic random_query();
		if ($urandom_range(9) == 0)
			evaluate_at($urandom);
		else
			evaluate_at(base_x - step_x + int'($urandom_range(0, (active_nodes + 1) * step_x)));
	endtask

	initial begin
		static logic [ndd_pkg::CFG_W-1:0] counts[12] = '{5'd2, 5'd16, 5'd0, 5'd1, 5'd31,
			5'd17, 5'd5, 5'd8, 5'd3, 5'd6, 5'd4, 5'd7};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: all nodes loaded once, with the extremes of x and y.
		for (int i = 0; i < 16; i++)
			send(ndd_pkg::OP_LOAD, i,
				(i == 0) ? 32'sh8000_0000 : (i == 15) ? 32'sh7FFF_FFFF : i <<< 16,
				(i == 3) ? 32'sh7FFF_FFFF : (i == 4) ? 32'sh8000_0000 : i <<< 14, 0);
		evaluate_at(0);
		evaluate_at(32'sh7FFF_FFFF);
		evaluate_at(32'sh8000_0000);
		send(ndd_pkg::OP_LOAD, 3, 2 <<< 16, 1 <<< 16, 0);
		evaluate_at(1 <<< 15);
		base_x = 0;
		step_x = 1 <<< 16;
		load_nodes(0, 10);
		evaluate_at(5 <<< 16);

		foreach (counts[p]) begin
			set_node_count(p < 10 ? counts[p] : 5'($urandom));
			// Coefficients built for the old count stay in use.
			evaluate_at($urandom);
			while (sent < 30 + (p + 1) * 65) begin
				quiet = (p == 5);
				if ($urandom_range(9) == 0)
					load_nodes($urandom_range(0, active_nodes - 1), active_nodes - 1);
				else
					load_nodes(0, active_nodes - 1);
				repeat ($urandom_range(2, 8)) random_query();
			end
			quiet = 0;
		end

		@(negedge clk);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("** newton_divided_difference_interp_unit: PASSED **");
		else
			$display("** newton_divided_difference_interp_unit: FAILED **");
		$finish;
	end

	initial begin
		#50ms;
		$display("** newton_divided_difference_interp_unit: FAILED **");
		$finish;
	end
endmodule

@@ newton_divided_difference_interp_unit.f @@
hdl/ndd_pkg.sv
hdl/ndd_ram.sv
hdl/ndd_div.sv
hdl/ndd_datapath.sv
hdl/ndd_ctrl.sv
hdl/newton_divided_difference_interp_unit.sv
sim/ndd_checker.sv
sim/testbench.sv
